/* design/hsvrgb_pkg.sv */
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; imported by hsvrgb_hue_split and hsv_to_rgb.
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

    // Hue sector, named by the channel that sits at full level and the one that moves
    typedef enum logic [2:0] {
        SECTOR_RED_GREEN  = 3'd0,
        SECTOR_GREEN_RED  = 3'd1,
        SECTOR_GREEN_BLUE = 3'd2,
        SECTOR_BLUE_GREEN = 3'd3,
        SECTOR_BLUE_RED   = 3'd4,
        SECTOR_RED_BLUE   = 3'd5
    } t_sector;

    localparam logic [7:0]  LEVEL_MAX      = 8'd255;
    localparam logic [5:0]  SECTOR_SPAN    = 6'd60;
    // floor(x / 15) = (x * 17477) >> 18, exact for x < 2**14
    localparam logic [14:0] DIV15_MUL      = 15'd17477;
    localparam int          DIV15_SHIFT    = 18;
    // floor(x / 6) = (x * 2731) >> 14, exact for x < 2**11
    localparam logic [11:0] DIV6_MUL       = 12'd2731;
    localparam int          DIV6_SHIFT     = 14;

    // floor(x / 255), exact over the full 16-bit range of an 8x8 product
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'd1 + 17'(x[15:8]);
        return 8'(s[16:8]);
    endfunction

endpackage

`default_nettype wire

/* design/hsvrgb_hue_split.sv */
// Hue split: two register stages that turn a 16-bit hue into a sector and
// a 0..250 fraction within that sector. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_hue_split
    import hsvrgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_hue,
    output t_sector          o_sector,
    output logic [7:0]       o_frac
);

    logic [10:0] r_q60;
    logic [15:0] r_hue;
    logic [28:0] w_div15;
    logic [22:0] w_div6;
    logic [8:0]  w_q6;
    logic [16:0] w_q60x60;
    logic [15:0] w_rem;
    logic [10:0] w_sec;
    logic [10:0] w_frac17;
    t_sector     r_sector;
    logic [7:0]  r_frac;

    // hue / 60 as (hue >> 2) / 15
    assign w_div15 = 29'(i_hue[15:2]) * 29'(DIV15_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q60 <= w_div15[28:DIV15_SHIFT];
            r_hue <= i_hue;
        end
    end

    // remainder within the 60-degree span, and sector = (hue / 60) mod 6
    assign w_q60x60 = {r_q60, 6'b0} - {4'b0, r_q60, 2'b0};
    assign w_rem    = r_hue - w_q60x60[15:0];
    assign w_div6   = 23'(r_q60) * 23'(DIV6_MUL);
    assign w_q6     = w_div6[22:DIV6_SHIFT];
    assign w_sec    = r_q60 - (11'({w_q6, 2'b0}) + 11'({w_q6, 1'b0}));
    // rem * 255 / 60 == rem * 17 / 4
    assign w_frac17 = {1'b0, w_rem[5:0], 4'b0} + 11'(w_rem[5:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= t_sector'(w_sec[2:0]);
            r_frac   <= w_frac17[9:2];
        end
    end

    assign o_sector = r_sector;
    assign o_frac   = r_frac;

endmodule

`default_nettype wire

/* design/hsv_to_rgb.sv */
// HSV to RGB converter, 8-bit channels, six-stage pipeline.
// Depends on hsvrgb_pkg and hsvrgb_hue_split.
//
// Input channel: i_valid / o_stall carry a request of hue (16 bits, any
// value, taken modulo 360), saturation and brightness. Output channel:
// o_valid / i_stall carry one RGB triple per request, in order.
// A request is taken on a clock edge with valid high and stall low.
//
// Throughput is one request per cycle while o_stall stays low; the
// pipeline depth is set by the two multiply-then-divide-by-255 steps,
// each split into a product stage and a reciprocal stage, after the two
// hue-split stages.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises; nothing is dropped or repeated. Bubbles stay in place.
// Reset (synchronous, active low) clears all valid bits; data registers are
// not reset. Zero saturation gives grey, all channels at the brightness.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb
    import hsvrgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_hue,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_brightness,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    logic        w_adv;
    logic [5:0]  r_vld;
    logic [5:0]  n_vld;

    // stage 1-2 side channel
    logic [7:0]  r_s1_sat, r_s1_val, r_s2_sat, r_s2_val;
    t_sector     w_s2_sector;
    logic [7:0]  w_s2_frac;

    // stage 3
    logic [15:0] r_s3_pf, r_s3_pg;
    logic [7:0]  r_s3_kl, r_s3_val;
    logic        r_s3_grey;
    t_sector     r_s3_sector;

    // stage 4
    logic [7:0]  r_s4_kf, r_s4_kg, r_s4_kl, r_s4_val;
    logic        r_s4_grey;
    t_sector     r_s4_sector;

    // stage 5
    logic [15:0] r_s5_fall, r_s5_rise, r_s5_lo;
    logic [7:0]  r_s5_val;
    logic        r_s5_grey;
    t_sector     r_s5_sector;

    // stage 6 (output)
    logic [7:0]  w_fall, w_rise, w_lo;
    logic [7:0]  n_red, n_green, n_blue;
    logic [7:0]  r_red, r_green, r_blue;

    assign o_stall = r_vld[5] & i_stall;
    assign w_adv   = ~o_stall;

    assign n_vld = {r_vld[4:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    hsvrgb_hue_split u_hue_split (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_hue    (i_hue),
        .o_sector (w_s2_sector),
        .o_frac   (w_s2_frac)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sat    <= i_saturation;
            r_s1_val    <= i_brightness;
            r_s2_sat    <= r_s1_sat;
            r_s2_val    <= r_s1_val;

            r_s3_pf     <= 16'(r_s2_sat) * 16'(w_s2_frac);
            r_s3_pg     <= 16'(r_s2_sat) * 16'(LEVEL_MAX - w_s2_frac);
            r_s3_kl     <= LEVEL_MAX - r_s2_sat;
            r_s3_val    <= r_s2_val;
            r_s3_grey   <= (r_s2_sat == 8'd0);
            r_s3_sector <= w_s2_sector;

            r_s4_kf     <= LEVEL_MAX - div255(r_s3_pf);
            r_s4_kg     <= LEVEL_MAX - div255(r_s3_pg);
            r_s4_kl     <= r_s3_kl;
            r_s4_val    <= r_s3_val;
            r_s4_grey   <= r_s3_grey;
            r_s4_sector <= r_s3_sector;

            r_s5_fall   <= 16'(r_s4_val) * 16'(r_s4_kf);
            r_s5_rise   <= 16'(r_s4_val) * 16'(r_s4_kg);
            r_s5_lo     <= 16'(r_s4_val) * 16'(r_s4_kl);
            r_s5_val    <= r_s4_val;
            r_s5_grey   <= r_s4_grey;
            r_s5_sector <= r_s4_sector;

            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
        end
    end

    assign w_fall = div255(r_s5_fall);
    assign w_rise = div255(r_s5_rise);
    assign w_lo   = div255(r_s5_lo);

    always_comb begin
        n_red   = r_s5_val;
        n_green = r_s5_val;
        n_blue  = r_s5_val;
        if (!r_s5_grey) begin
            case (r_s5_sector)
                SECTOR_RED_GREEN: begin
                    n_red = r_s5_val; n_green = w_rise; n_blue = w_lo;
                end
                SECTOR_GREEN_RED: begin
                    n_red = w_fall; n_green = r_s5_val; n_blue = w_lo;
                end
                SECTOR_GREEN_BLUE: begin
                    n_red = w_lo; n_green = r_s5_val; n_blue = w_rise;
                end
                SECTOR_BLUE_GREEN: begin
                    n_red = w_lo; n_green = w_fall; n_blue = r_s5_val;
                end
                SECTOR_BLUE_RED: begin
                    n_red = w_rise; n_green = w_lo; n_blue = r_s5_val;
                end
                default: begin
                    n_red = r_s5_val; n_green = w_lo; n_blue = w_fall;
                end
            endcase
        end
    end

    assign o_valid = r_vld[5];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // a held pipeline always has a result waiting at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("o_stall raised with no result at the output");

    // a request accepted while the pipeline keeps advancing reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !o_stall ##1 !o_stall ##1 !o_stall
            ##1 !o_stall ##1 !o_stall |=> o_valid)
        else $error("accepted request did not reach the output in six cycles");

    // a stalled result is still there on the next cycle
    a_stall_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while the receiver stalled");

endmodule

`default_nettype wire
